// ----- design/cdfr_pkg.sv -----
`default_nettype none

package cdfr_pkg;

   // Default sizes and fixed limits
   localparam int BUFFER_BYTES_DEF = 256;
   localparam int CHUNK_BYTES_DEF  = 8;
   localparam int CHUNK_MAX        = 8;
   localparam int MAX_RESULTS      = 32;
   localparam int MIN_FRAME        = 4;
   localparam int FRAME_OVERHEAD   = 3;

   // Modbus CRC-16, reflected form
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Register reset values
   localparam logic [8:0]  RX_CAPACITY_RESET    = 9'd256;
   localparam logic [7:0]  PDU_CAPACITY_RESET   = 8'd253;
   localparam logic [15:0] IDLE_TIMEOUT_RESET   = 16'd10;
   localparam logic        TIMEOUT_ENABLE_RESET = 1'b0;

   typedef enum logic [1:0] {
      CSR_RX_CAPACITY,
      CSR_PDU_CAPACITY,
      CSR_IDLE_TIMEOUT,
      CSR_TIMEOUT_ENABLE
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_CHUNK,
      STATUS_FULL,
      STATUS_LONG,
      STATUS_IDLE
   } status_type;

   typedef enum logic [2:0] {
      VERDICT_NONE,
      VERDICT_FULL,
      VERDICT_LONG,
      VERDICT_IDLE,
      VERDICT_EMIT
   } verdict_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FOLD,
      ST_CHECK,
      ST_ERR,
      ST_READ,
      ST_PACK,
      ST_PUSH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic take;
      logic fold;
      logic emit_start;
      logic pack;
      logic load_err;
      logic load_chunk;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      verdict_type verdict;
      logic        fold_last;
      logic        pack_end;
      logic        pay_empty;
      logic        final_chunk;
      logic        out_free;
   } stat_type;

endpackage

`default_nettype wire

// ----- design/cdfr_dpath.sv -----
`default_nettype none

module cdfr_dpath #(
   parameter int BUFFER_BYTES = cdfr_pkg::BUFFER_BYTES_DEF,
   parameter int CHUNK_BYTES  = cdfr_pkg::CHUNK_BYTES_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  cdfr_pkg::cmd_type      cmd,
   output cdfr_pkg::stat_type     stat,
   input  wire                    csr_we,
   input  wire  [1:0]             csr_index,
   input  wire  [15:0]            csr_wdata,
   input  wire                    in_func,
   input  wire  [7:0]             in_byte,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [71:0]            rsp_tdata,
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast
);

   localparam int AW        = $clog2(BUFFER_BYTES);
   localparam int FW        = $clog2(BUFFER_BYTES + 1);
   localparam int CMPW      = (FW > 9) ? FW : 9;
   localparam int PDU_LIMIT = cdfr_pkg::MAX_RESULTS * CHUNK_BYTES;
   localparam int CIW       = $clog2(cdfr_pkg::CHUNK_MAX);

   // Configuration
   logic [8:0]  rx_cap_ff;
   logic [7:0]  pdu_cap_ff;
   logic [15:0] timeout_ff;
   logic        to_en_ff;

   // Frame state
   logic [FW-1:0] fill_ff;
   logic [15:0]   crc_ff;
   logic [15:0]   idle_ff;
   logic [7:0]    hist1_ff;
   logic [7:0]    hist2_ff;
   logic          func_ff;
   logic          stored_ff;
   logic          fold_en_ff;
   logic [2:0]    bit_ff;

   // Payload readout
   logic [FW-1:0] pos_ff;
   logic [3:0]    nb_ff;
   logic [7:0]    chunk_ff [cdfr_pkg::CHUNK_MAX];
   logic [7:0]    mem [BUFFER_BYTES];
   logic [7:0]    rdata_ff;

   // Output word
   logic                 rsp_valid_ff;
   cdfr_pkg::status_type rsp_status_ff;
   logic [63:0]          rsp_chunk_ff;
   logic [3:0]           rsp_nb_ff;
   logic                 rsp_last_ff;

   logic [CMPW-1:0]       cap_w;
   logic [CMPW-1:0]       fill_w;
   logic [FW-1:0]         len;
   logic [CMPW-1:0]       len_w;
   logic                  room;
   logic                  crc_hit;
   logic                  too_long;
   logic                  timed_out;
   logic [FW-1:0]         pos_next;
   logic [3:0]            nb_next;
   logic [AW-1:0]         raddr;
   logic [63:0]           chunk_word;
   cdfr_pkg::verdict_type verdict;
   cdfr_pkg::status_type  err_status;

   // Capacity clamp and frame checks
   always_comb begin
      cap_w     = (CMPW'(rx_cap_ff) > CMPW'(BUFFER_BYTES)) ? CMPW'(BUFFER_BYTES)
                                                          : CMPW'(rx_cap_ff);
      fill_w    = CMPW'(fill_ff);
      room      = fill_w < cap_w;
      len       = fill_ff - FW'(cdfr_pkg::FRAME_OVERHEAD);
      len_w     = CMPW'(len);
      crc_hit   = (fill_w >= CMPW'(cdfr_pkg::MIN_FRAME)) && ({hist1_ff, hist2_ff} == crc_ff);
      too_long  = (len_w > CMPW'(pdu_cap_ff)) || (len_w > CMPW'(PDU_LIMIT));
      timed_out = to_en_ff && (fill_ff != '0) && (idle_ff >= timeout_ff);
   end

   // Decide what the word just taken leads to
   always_comb begin
      verdict = cdfr_pkg::VERDICT_NONE;
      if (!func_ff) begin
         if (!stored_ff) verdict = cdfr_pkg::VERDICT_FULL;
         else if (crc_hit) verdict = too_long ? cdfr_pkg::VERDICT_LONG : cdfr_pkg::VERDICT_EMIT;
         else if (!room) verdict = cdfr_pkg::VERDICT_FULL;
         else if (timed_out) verdict = cdfr_pkg::VERDICT_IDLE;
      end else begin
         if ((fill_ff != '0) && !room) verdict = cdfr_pkg::VERDICT_FULL;
         else if (timed_out) verdict = cdfr_pkg::VERDICT_IDLE;
      end
   end

   always_comb begin
      case (verdict)
         cdfr_pkg::VERDICT_FULL: err_status = cdfr_pkg::STATUS_FULL;
         cdfr_pkg::VERDICT_LONG: err_status = cdfr_pkg::STATUS_LONG;
         default:                err_status = cdfr_pkg::STATUS_IDLE;
      endcase
   end

   // Readout bookkeeping
   always_comb begin
      pos_next = pos_ff + FW'(1);
      nb_next  = nb_ff + 4'd1;
      raddr    = AW'(pos_next);
      for (int i = 0; i < cdfr_pkg::CHUNK_MAX; i++) begin
         chunk_word[8*i +: 8] = chunk_ff[i];
      end
   end

   always_comb begin
      stat.verdict     = verdict;
      stat.fold_last   = (bit_ff == 3'd7);
      stat.pack_end    = (nb_next == 4'(CHUNK_BYTES)) || (pos_next == len);
      stat.pay_empty   = (len == '0);
      stat.final_chunk = (pos_ff == len);
      stat.out_free    = !rsp_valid_ff || rsp_tready;
   end

   // Control state, CRC and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_cap_ff    <= cdfr_pkg::RX_CAPACITY_RESET;
         pdu_cap_ff   <= cdfr_pkg::PDU_CAPACITY_RESET;
         timeout_ff   <= cdfr_pkg::IDLE_TIMEOUT_RESET;
         to_en_ff     <= cdfr_pkg::TIMEOUT_ENABLE_RESET;
         fill_ff      <= '0;
         crc_ff       <= cdfr_pkg::CRC_INIT;
         idle_ff      <= '0;
         func_ff      <= 1'b1;
         stored_ff    <= 1'b0;
         fold_en_ff   <= 1'b0;
         bit_ff       <= '0;
         pos_ff       <= '0;
         nb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (cdfr_pkg::csr_index_type'(csr_index))
               cdfr_pkg::CSR_RX_CAPACITY:    rx_cap_ff  <= csr_wdata[8:0];
               cdfr_pkg::CSR_PDU_CAPACITY:   pdu_cap_ff <= csr_wdata[7:0];
               cdfr_pkg::CSR_IDLE_TIMEOUT:   timeout_ff <= csr_wdata;
               cdfr_pkg::CSR_TIMEOUT_ENABLE: to_en_ff   <= csr_wdata[0];
               default: ;
            endcase
         end

         // Take a word: store a byte and seed the CRC fold, or count a tick
         if (cmd.take) begin
            func_ff    <= in_func;
            bit_ff     <= '0;
            stored_ff  <= 1'b0;
            fold_en_ff <= 1'b0;
            if (!in_func) begin
               idle_ff <= '0;
               if (room) begin
                  fill_ff   <= fill_ff + FW'(1);
                  stored_ff <= 1'b1;
                  if (fill_ff >= FW'(cdfr_pkg::FRAME_OVERHEAD - 1)) begin
                     crc_ff     <= crc_ff ^ {8'h00, hist2_ff};
                     fold_en_ff <= 1'b1;
                  end
               end
            end else if (idle_ff != 16'hFFFF) begin
               idle_ff <= idle_ff + 16'd1;
            end
         end

         // Shift the CRC one bit
         if (cmd.fold) begin
            bit_ff <= bit_ff + 3'd1;
            if (fold_en_ff) begin
               crc_ff <= crc_ff[0] ? ((crc_ff >> 1) ^ cdfr_pkg::CRC_POLY) : (crc_ff >> 1);
            end
         end

         if (cmd.emit_start) begin
            pos_ff <= '0;
            nb_ff  <= '0;
         end

         if (cmd.pack) begin
            pos_ff <= pos_next;
            nb_ff  <= nb_next;
         end

         // Drop the buffer after an error or the last chunk
         if (cmd.load_err || (cmd.load_chunk && stat.final_chunk)) begin
            fill_ff <= '0;
            crc_ff  <= cdfr_pkg::CRC_INIT;
         end

         if (cmd.load_chunk) begin
            nb_ff <= '0;
         end

         if (cmd.load_err || cmd.load_chunk) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Frame buffer: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.take && !in_func && room) begin
         mem[fill_ff[AW-1:0]] <= in_byte;
      end
      rdata_ff <= mem[raddr];
   end

   // Byte history, chunk assembly and output word
   always_ff @(posedge clock) begin
      if (cmd.take && !in_func && room) begin
         hist1_ff <= in_byte;
         hist2_ff <= hist1_ff;
      end

      if (cmd.emit_start || cmd.load_chunk) begin
         for (int i = 0; i < cdfr_pkg::CHUNK_MAX; i++) begin
            chunk_ff[i] <= 8'h00;
         end
      end else if (cmd.pack) begin
         chunk_ff[nb_ff[CIW-1:0]] <= rdata_ff;
      end

      if (cmd.load_err) begin
         rsp_status_ff <= err_status;
         rsp_chunk_ff  <= '0;
         rsp_nb_ff     <= '0;
         rsp_last_ff   <= 1'b1;
      end else if (cmd.load_chunk) begin
         rsp_status_ff <= cdfr_pkg::STATUS_CHUNK;
         rsp_chunk_ff  <= chunk_word;
         rsp_nb_ff     <= nb_ff;
         rsp_last_ff   <= stat.final_chunk;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, rsp_nb_ff, rsp_chunk_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      CMPW'(fill_ff) <= CMPW'(BUFFER_BYTES))
      else $error("fill count beyond buffer size");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_err || cmd.load_chunk) |-> stat.out_free)
      else $error("output word overwritten before it was taken");

   a_final_drop: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_chunk && stat.final_chunk) |=> (fill_ff == '0 && crc_ff == cdfr_pkg::CRC_INIT))
      else $error("buffer not dropped after last chunk");

   a_pack_room: assert property (@(posedge clock) disable iff (reset)
      cmd.pack |-> (nb_ff < 4'(CHUNK_BYTES)))
      else $error("byte packed into a full chunk");
`endif

endmodule

`default_nettype wire

// ----- design/cdfr_ctrl.sv -----
`default_nettype none

module cdfr_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   input  wire                 req_tuser,
   output logic                req_tready,
   input  cdfr_pkg::stat_type  stat,
   output cdfr_pkg::cmd_type   cmd
);

   cdfr_pkg::state_type state_ff;
   cdfr_pkg::state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cdfr_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = req_tuser ? cdfr_pkg::ST_CHECK : cdfr_pkg::ST_FOLD;
         end
         cdfr_pkg::ST_FOLD: begin
            if (stat.fold_last) state_in = cdfr_pkg::ST_CHECK;
         end
         cdfr_pkg::ST_CHECK: begin
            unique case (stat.verdict)
               cdfr_pkg::VERDICT_NONE: state_in = cdfr_pkg::ST_IDLE;
               cdfr_pkg::VERDICT_EMIT:
                  state_in = stat.pay_empty ? cdfr_pkg::ST_PUSH : cdfr_pkg::ST_READ;
               default: state_in = cdfr_pkg::ST_ERR;
            endcase
         end
         cdfr_pkg::ST_ERR: begin
            if (stat.out_free) state_in = cdfr_pkg::ST_IDLE;
         end
         cdfr_pkg::ST_READ: state_in = cdfr_pkg::ST_PACK;
         cdfr_pkg::ST_PACK: begin
            state_in = stat.pack_end ? cdfr_pkg::ST_PUSH : cdfr_pkg::ST_READ;
         end
         cdfr_pkg::ST_PUSH: begin
            if (stat.out_free)
               state_in = stat.final_chunk ? cdfr_pkg::ST_IDLE : cdfr_pkg::ST_READ;
         end
         default: state_in = cdfr_pkg::ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         cdfr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.take   = req_tvalid;
         end
         cdfr_pkg::ST_FOLD:  cmd.fold = 1'b1;
         cdfr_pkg::ST_CHECK: cmd.emit_start = (stat.verdict == cdfr_pkg::VERDICT_EMIT);
         cdfr_pkg::ST_ERR:   cmd.load_err = stat.out_free;
         cdfr_pkg::ST_READ:  ;
         cdfr_pkg::ST_PACK:  cmd.pack = 1'b1;
         cdfr_pkg::ST_PUSH:  cmd.load_chunk = stat.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cdfr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/crc_delimited_frame_receiver.sv -----
`default_nettype none

// Channel  Dir  tdata (low bit up)               tuser           tlast
// req_     in   byte_value[7:0]                  func            -
// rsp_     out  pdu_chunk[63:0], chunk_bytes,    status[1:0]     last
//               four zero bits
// csr_     in   write enable, index, 16-bit data (no read-back)
//
// A byte is handled as a take, eight bit-serial CRC shifts and one check.
// A timer tick goes from the take straight to the check. An error adds a state
// that loads the result. A complete frame adds a buffer read and a pack per
// payload byte, plus a push per chunk; the registered buffer read sets this.
// A result waits in the output register while the next word is taken; work
// stalls only when a new result meets an untaken one. Reset leaves the frame
// buffer as it is; no clearing pass.
module crc_delimited_frame_receiver #(
   parameter int BUFFER_BYTES = cdfr_pkg::BUFFER_BYTES_DEF,
   parameter int CHUNK_BYTES  = cdfr_pkg::CHUNK_BYTES_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // byte_value
   input  wire         req_tuser,   // func
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [71:0] rsp_tdata,   // pdu_chunk, chunk_bytes, zero pad
   output logic [1:0]  rsp_tuser,   // status
   output logic        rsp_tlast,
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [15:0] csr_wdata
);

   cdfr_pkg::cmd_type  cmd;
   cdfr_pkg::stat_type stat;

   cdfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cdfr_dpath #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .CHUNK_BYTES  (CHUNK_BYTES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_func    (req_tuser),
      .in_byte    (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
